// ===== src/glzw_pkg.sv =====
// Package for the GIF LZW pixel decoder: widths, status codes, register indexes.
// No dependencies.
package glzw_pkg;
  localparam int TABLE_DEPTH   = 4096;
  localparam int MAX_CODE_BITS = 12;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [2:0] ST_BYTE_TAKEN  = 3'd0;
  localparam logic [2:0] ST_PIXEL       = 3'd1;
  localparam logic [2:0] ST_NEED_BYTES  = 3'd2;
  localparam logic [2:0] ST_FINISHED    = 3'd3;
  localparam logic [2:0] ST_REFUSED     = 3'd4;

  localparam logic [2:0] REG_MIN_BITS = 3'd0;
  localparam logic [2:0] REG_OFS_X    = 3'd1;
  localparam logic [2:0] REG_OFS_Y    = 3'd2;
  localparam logic [2:0] REG_FRM_W    = 3'd3;
  localparam logic [2:0] REG_FRM_H    = 3'd4;
  localparam logic [2:0] REG_CNV_W    = 3'd5;
  localparam logic [2:0] REG_CNV_H    = 3'd6;
  localparam logic [2:0] REG_INTERL   = 3'd7;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] pixel_address;
    logic [7:0]  color_index;
    logic        pixel_inside;
    logic        last_pixel;
  } out_item_t;

  // Interlace pass tables, pass 0 is plain order.
  function automatic logic [3:0] pass_step(input logic [2:0] p);
    case (p)
      3'd0: pass_step = 4'd1;
      3'd1: pass_step = 4'd8;
      3'd2: pass_step = 4'd8;
      3'd3: pass_step = 4'd4;
      default: pass_step = 4'd2;
    endcase
  endfunction

  function automatic logic [2:0] pass_start(input logic [2:0] p);
    case (p)
      3'd2: pass_start = 3'd4;
      3'd3: pass_start = 3'd2;
      3'd4: pass_start = 3'd1;
      default: pass_start = 3'd0;
    endcase
  endfunction
endpackage

// ===== src/glzw_if.sv =====
// Valid/ready channel interface carrying one payload.
// Depends on nothing; payload type is a parameter.
interface glzw_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/gif_lzw_pixel_decoder_top.sv =====
// Top level of the GIF LZW pixel decoder: bit buffer, code tables, stack, output.
// Depends on glzw_pkg, glzw_if and glzw_placer.
//
//  channel | dir | payload                                   | handshake
//  in_     | in  | command, data_byte                        | valid/ready
//  out_    | out | status, pixel_address, color_index, ...   | valid/ready
//  cfg_    | in  | 3-bit index, 16-bit data                  | write enable
//
// A byte request is answered the cycle after it is taken; the next request is
// taken only once that answer has been taken. A pixel request with symbols on
// the stack goes through fetch, pop, address and output before it is answered.
// On an empty stack each code first goes through extract and interpret, then
// one walk step per symbol of its string, one table read per chained symbol;
// running out of bits is answered from fetch, the end code from interpret.
// Address uses one 17x16 multiply with a registered product.
// Reset is synchronous; tables are undefined until written. A stalled result
// holds in the output register and no new request is taken meanwhile.
module gif_lzw_pixel_decoder_top #(
  parameter int TableDepth  = glzw_pkg::TABLE_DEPTH,
  parameter int MaxCodeBits = glzw_pkg::MAX_CODE_BITS
) (
  input  logic clk,
  input  logic rst_n,
  glzw_if.sink   in_ch,
  glzw_if.source out_ch,
  input  logic                       cfg_we,
  input  logic [glzw_pkg::CFG_AW-1:0] cfg_index,
  input  logic [glzw_pkg::CFG_DW-1:0] cfg_data
);
  localparam int AW = $clog2(TableDepth);
  localparam int LW = AW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;  // check stack / bits
  localparam logic [3:0] S_CODE  = 4'd2;  // interpret extracted code
  localparam logic [3:0] S_WALK  = 4'd3;  // table read returns
  localparam logic [3:0] S_POP   = 4'd4;  // stack read returns
  localparam logic [3:0] S_ADDR  = 4'd5;  // product ready
  localparam logic [3:0] S_OUT   = 4'd6;

  // configuration
  logic [3:0]  min_bits_r;
  logic [15:0] ofs_x_r, ofs_y_r, frm_w_r, frm_h_r, cnv_w_r, cnv_h_r;
  logic        interl_r, restart;

  // memories
  logic [AW-1:0] prefix_mem [TableDepth];
  logic [7:0]    suffix_mem [TableDepth];
  logic [7:0]    stack_mem  [TableDepth];
  logic [AW-1:0] prefix_rd;
  logic [7:0]    suffix_rd, stack_rd;

  // decoder state
  logic [3:0]    state_r;
  logic [LW-1:0] level_r;
  logic [23:0]   bitbuf_r;
  logic [4:0]    held_r;
  logic [7:0]    left_r;
  logic [3:0]    width_r;
  logic [LW-1:0] slot_r, limit_r;
  logic [AW-1:0] old_r, code_r, cin_r;
  logic [7:0]    first_r;
  logic          fin_r, aclear_r, big_r;
  glzw_pkg::out_item_t res_r;
  logic          out_v_r;
  logic [31:0]   prod_r;
  logic          inside_r, last_r;
  logic [7:0]    color_r;
  logic [16:0]   px_r, py_r;

  logic [3:0] m;
  assign m = (min_bits_r < 4'd2) ? 4'd2 : (min_bits_r > 4'd9) ? 4'd9 : min_bits_r;
  logic [LW-1:0] clear_c, newc_c;
  assign clear_c = LW'(1) << m;
  assign newc_c  = clear_c + LW'(2);

  assign restart = cfg_we && (cfg_index <= glzw_pkg::REG_INTERL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bits_r <= 4'd8; ofs_x_r <= '0; ofs_y_r <= '0; frm_w_r <= 16'd1;
      frm_h_r <= 16'd1; cnv_w_r <= 16'd1; cnv_h_r <= 16'd1; interl_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        glzw_pkg::REG_MIN_BITS: min_bits_r <= cfg_data[3:0];
        glzw_pkg::REG_OFS_X:    ofs_x_r <= cfg_data;
        glzw_pkg::REG_OFS_Y:    ofs_y_r <= cfg_data;
        glzw_pkg::REG_FRM_W:    frm_w_r <= cfg_data;
        glzw_pkg::REG_FRM_H:    frm_h_r <= cfg_data;
        glzw_pkg::REG_CNV_W:    cnv_w_r <= cfg_data;
        glzw_pkg::REG_CNV_H:    cnv_h_r <= cfg_data;
        default:                interl_r <= cfg_data[0];
      endcase
    end
  end

  // restart value of m uses the incoming register value
  logic [3:0] m_new, mb_new;
  assign mb_new = (cfg_index == glzw_pkg::REG_MIN_BITS) ? cfg_data[3:0] : min_bits_r;
  assign m_new  = (mb_new < 4'd2) ? 4'd2 : (mb_new > 4'd9) ? 4'd9 : mb_new;
  logic interl_new;
  assign interl_new = (cfg_index == glzw_pkg::REG_INTERL) ? cfg_data[0] : interl_r;

  // position tracker
  logic [15:0] col, row;
  logic        frame_done, place_step;
  glzw_placer u_placer (
    .clk, .rst_n, .restart(restart), .interlaced(interl_new),
    .frame_width(frm_w_r), .frame_height(frm_h_r), .step(place_step),
    .column(col), .row(row), .frame_done(frame_done)
  );

  // canvas row and row start address of the pixel being popped
  logic [16:0] py_sum;
  logic [31:0] prod_full;
  assign py_sum    = {1'b0, ofs_y_r} + {1'b0, row};
  assign prod_full = {15'd0, py_sum} * {16'd0, cnv_w_r};

  // memory control
  logic          tab_we, stk_we;
  logic [AW-1:0] tab_wa, tab_ra, stk_wa, stk_ra;
  logic [AW-1:0] tab_wp;
  logic [7:0]    tab_ws, stk_wd;

  always_ff @(posedge clk) begin
    if (tab_we) begin
      prefix_mem[tab_wa] <= tab_wp;
      suffix_mem[tab_wa] <= tab_ws;
    end
    prefix_rd <= prefix_mem[tab_ra];
    suffix_rd <= suffix_mem[tab_ra];
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    stack_rd <= stack_mem[stk_ra];
  end

  logic [11:0] cmask;
  logic [AW-1:0] cx;
  assign cmask = 12'((13'd1 << width_r) - 13'd1);
  assign cx    = AW'(bitbuf_r[11:0] & cmask);

  logic in_fire, out_fire;
  logic in_ready_w;
  assign in_ready_w = (state_r == S_IDLE) && !out_v_r;
  assign in_ch.ready  = in_ready_w;
  assign in_fire      = in_ch.valid && in_ready_w;
  assign out_ch.valid   = out_v_r;
  assign out_ch.payload = res_r;
  assign out_fire       = out_v_r && out_ch.ready;

  always_comb begin
    tab_we = 1'b0; tab_wa = slot_r[AW-1:0]; tab_wp = old_r; tab_ws = first_r;
    tab_ra = code_r; stk_we = 1'b0; stk_wa = level_r[AW-1:0]; stk_wd = '0;
    stk_ra = AW'(level_r - LW'(1));
    place_step = 1'b0;
    if (state_r == S_WALK) begin
      if ({1'b0, code_r} >= newc_c && level_r < LW'(TableDepth)) begin
        stk_we = 1'b1; stk_wd = suffix_rd;
        tab_ra = prefix_rd;
      end else begin
        stk_we = level_r < LW'(TableDepth); stk_wd = code_r[7:0];
        if (slot_r < limit_r) tab_we = 1'b1;
        tab_ws = code_r[7:0];
      end
    end
    if (state_r == S_CODE && aclear_r == 1'b0 && big_r) begin
      stk_we = level_r < LW'(TableDepth); stk_wd = first_r;
    end
    if (state_r == S_CODE && aclear_r && cin_r != clear_c[AW-1:0]) begin
      stk_we = 1'b1;
      stk_wd = ({1'b0, cin_r} >= slot_r) ? 8'd0 : cin_r[7:0];
    end
    if (state_r == S_ADDR) place_step = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      state_r <= S_IDLE;
      level_r <= '0; bitbuf_r <= '0; held_r <= '0; left_r <= '0;
      width_r <= (rst_n ? m_new : 4'd8) + 4'd1;
      slot_r  <= (LW'(1) << (rst_n ? m_new : 4'd8)) + LW'(2);
      limit_r <= LW'(1) << ((rst_n ? m_new : 4'd8) + 4'd1);
      old_r <= '0; first_r <= '0; fin_r <= 1'b0; aclear_r <= 1'b1;
      out_v_r <= 1'b0;
      res_r <= '0;
    end else begin
      // result register is cleared once taken, so fields not set read as zero
      if (out_fire) begin
        out_v_r <= 1'b0;
        res_r <= '0;
      end
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          if (!in_ch.payload.command) begin
            out_v_r <= 1'b1;
            if (fin_r) res_r.status <= glzw_pkg::ST_REFUSED;
            else if (left_r == 8'd0) left_r <= in_ch.payload.data_byte;
            else if (held_r > 5'd16) res_r.status <= glzw_pkg::ST_REFUSED;
            else begin
              bitbuf_r <= bitbuf_r | (24'(in_ch.payload.data_byte) << held_r);
              held_r <= held_r + 5'd8;
              left_r <= left_r - 8'd1;
            end
          end else if (fin_r) begin
            res_r.status <= glzw_pkg::ST_FINISHED; out_v_r <= 1'b1;
          end else state_r <= S_FETCH;
        end
        S_FETCH: begin
          if (level_r != '0) state_r <= S_POP;
          else if (held_r < {1'b0, width_r}) begin
            res_r.status <= glzw_pkg::ST_NEED_BYTES; out_v_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            cin_r <= cx;
            big_r <= {1'b0, cx} >= slot_r;
            code_r <= ({1'b0, cx} >= slot_r) ? old_r : cx;
            bitbuf_r <= bitbuf_r >> width_r;
            held_r <= held_r - {1'b0, width_r};
            state_r <= S_CODE;
          end
        end
        S_CODE: begin
          if ({1'b0, cin_r} == clear_c) begin
            width_r <= m + 4'd1; slot_r <= newc_c;
            limit_r <= LW'(1) << (m + 4'd1); aclear_r <= 1'b1;
            state_r <= S_FETCH;
          end else if ({1'b0, cin_r} == clear_c + LW'(1)) begin
            fin_r <= 1'b1; res_r.status <= glzw_pkg::ST_FINISHED;
            out_v_r <= 1'b1; state_r <= S_IDLE;
          end else if (aclear_r) begin
            old_r <= ({1'b0, cin_r} >= slot_r) ? '0 : cin_r;
            first_r <= ({1'b0, cin_r} >= slot_r) ? 8'd0 : cin_r[7:0];
            level_r <= level_r + LW'(1);
            aclear_r <= 1'b0; state_r <= S_FETCH;
          end else begin
            if (big_r && level_r < LW'(TableDepth)) level_r <= level_r + LW'(1);
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          if ({1'b0, code_r} >= newc_c && level_r < LW'(TableDepth)) begin
            level_r <= level_r + LW'(1);
            code_r <= prefix_rd;
          end else begin
            if (level_r < LW'(TableDepth)) level_r <= level_r + LW'(1);
            first_r <= code_r[7:0];
            old_r <= big_r ? slot_r[AW-1:0] : cin_r;
            if (slot_r < limit_r) begin
              slot_r <= slot_r + LW'(1);
              if (slot_r + LW'(1) >= limit_r && width_r < 4'(MaxCodeBits)) begin
                limit_r <= limit_r << 1; width_r <= width_r + 4'd1;
              end
            end else if (width_r < 4'(MaxCodeBits)) begin
              limit_r <= limit_r << 1; width_r <= width_r + 4'd1;
            end
            state_r <= S_FETCH;
          end
        end
        S_POP: begin
          color_r <= stack_rd;
          level_r <= level_r - LW'(1);
          px_r <= {1'b0, ofs_x_r} + {1'b0, col};
          py_r <= py_sum;
          prod_r <= prod_full;
          state_r <= S_ADDR;
        end
        S_ADDR: begin
          inside_r <= (px_r < {1'b0, cnv_w_r}) && (py_r < {1'b0, cnv_h_r});
          last_r   <= frame_done;
          prod_r   <= prod_r + 32'(px_r);
          if (frame_done) begin fin_r <= 1'b1; level_r <= '0; end
          state_r <= S_OUT;
        end
        S_OUT: begin
          res_r.status <= glzw_pkg::ST_PIXEL;
          res_r.color_index <= color_r;
          res_r.pixel_inside <= inside_r;
          res_r.pixel_address <= inside_r ? prod_r : 32'd0;
          res_r.last_pixel <= last_r;
          out_v_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // walk reads the entry fetched in the state before: first read issued in S_CODE
  // (tab_ra defaults to code_r), so table data is valid on entry to S_WALK.

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready && !restart |=> out_v_r && $stable(res_r))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready_w)
    else $error("request taken while busy");
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(TableDepth))
    else $error("stack overflow");
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= 5'd24)
    else $error("bit buffer overfilled");
endmodule

// ===== src/glzw_placer.sv =====
// Pixel position tracker: column, row, interlace pass.
// Depends on glzw_pkg. Address multiply is registered in the top level path.
module glzw_placer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        restart,
  input  logic        interlaced,
  input  logic [15:0] frame_width,
  input  logic [15:0] frame_height,
  input  logic        step,
  output logic [15:0] column,
  output logic [15:0] row,
  output logic        frame_done
);
  logic [15:0] column_r, column_nxt, row_r, row_nxt;
  logic [2:0]  pass_r, pass_nxt;
  logic [16:0] y;
  logic [2:0]  p;
  logic        done;

  always_comb begin
    column_nxt = column_r;
    row_nxt    = row_r;
    pass_nxt   = pass_r;
    done       = 1'b0;
    p          = pass_r;
    y          = 17'd0;
    if ({1'b0, column_r} + 17'd1 < {1'b0, frame_width}) begin
      column_nxt = column_r + 16'd1;
    end else begin
      column_nxt = 16'd0;
      y = {1'b0, row_r} + {13'd0, glzw_pkg::pass_step(p)};
      for (int i = 0; i < 3; i++) begin
        if (y >= {1'b0, frame_height} && p >= 3'd1 && p <= 3'd3) begin
          p = p + 3'd1;
          y = {14'd0, glzw_pkg::pass_start(p)};
        end
      end
      pass_nxt = p;
      if (y >= {1'b0, frame_height}) done = 1'b1;
      else row_nxt = y[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      column_r <= '0;
      row_r    <= '0;
      pass_r   <= (rst_n && interlaced) ? 3'd1 : 3'd0;
    end else if (step) begin
      column_r <= column_nxt;
      row_r    <= row_nxt;
      pass_r   <= pass_nxt;
    end
  end

  assign column     = column_r;
  assign row        = row_r;
  assign frame_done = done;
endmodule
